@@ design/oal_pkg.sv @@
`default_nettype none

package oal_pkg;

	// Field widths of one command and one result
	localparam int FUNC_W      = 4;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 5;
	localparam int STAT_W      = 3;
	// A list command reports at most this many elements
	localparam int MAX_RESULTS = 16;

	typedef enum logic [FUNC_W-1:0] {
		FN_SEARCH     = 4'd0,
		FN_INS_FRONT  = 4'd1,
		FN_INS_END    = 4'd2,
		FN_INS_AFTER  = 4'd3,
		FN_INS_BEFORE = 4'd4,
		FN_DEL_FRONT  = 4'd5,
		FN_DEL_END    = 4'd6,
		FN_DEL_AFTER  = 4'd7,
		FN_DEL_BEFORE = 4'd8,
		FN_LIST       = 4'd9
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_EMPTY      = 3'd2,
		ST_NOTFOUND   = 3'd3,
		ST_NONEIGHBOR = 3'd4
	} status_t;

	// One result transaction
	typedef struct packed {
		status_t                  status;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] data;
		logic [CNT_W-1:0]         count;
		logic                     last;
	} res_t;

endpackage

`default_nettype wire

@@ design/ordered_array_list_engine_top.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------
// in       | in_valid / in_stall  | func, key, value
// out      | out_valid / out_stall| status, index, data, count, last
//
// One command at a time. A key search reads one element per cycle from the
// store memory; an insert or delete then shifts one element per cycle through
// that memory's separate read and write ports. A list reads, captures and then
// emits each element in turn, pausing while the result register is stalled.
// Reset clears the element count and the control registers; the store needs no clearing.
// in_stall is high while a command is in progress; out_stall holds the result
// register and pauses a list or the next result.
`default_nettype none

module ordered_array_list_engine_top import oal_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [FUNC_W-1:0]        func,
	input  wire logic signed [DATA_W-1:0] key,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [STAT_W-1:0]             status,
	output logic [IDX_W-1:0]              index,
	output logic signed [DATA_W-1:0]      data,
	output logic [CNT_W-1:0]              count,
	output logic                          last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SRCH = 7'b0000010,
		S_UP   = 7'b0000100,
		S_DN   = 7'b0001000,
		S_LRD  = 7'b0010000,
		S_LCAP = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [FUNC_W-1:0]        func_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CW-1:0]            count_q;
	logic [AW-1:0]            pos_q;
	logic [AW-1:0]            rp_q;
	logic [CW-1:0]            rem_q;
	logic [CW-1:0]            sp_q;
	logic [AW-1:0]            lp_q;
	logic                     more_q;
	res_t                     res_q;

	logic                     sv_s1;
	logic                     first_s1;
	logic [AW-1:0]            si_s1;
	logic [AW-1:0]            widx_s1;
	logic [DATA_W-1:0]        rdata_s1;
	logic [DATA_W-1:0]        mem_q [CAPACITY];

	logic                     re;
	logic [AW-1:0]            raddr;
	logic                     we;
	logic [AW-1:0]            waddr;
	logic [DATA_W-1:0]        wdata;

	logic                     is_full;
	logic                     is_empty;
	logic                     srch_hit;
	logic                     srch_end;
	logic [CW-1:0]            lp_nx;
	logic                     lst;
	logic                     out_free;
	res_t                     ld_res;

	logic                     go_emit;
	logic                     go_srch;
	logic                     go_up;
	logic                     go_dn;
	logic                     go_list;
	logic [AW-1:0]            new_pos;
	res_t                     new_res;

	assign in_stall = (state_q != S_IDLE);
	assign is_full  = (count_q >= CW'(CAPACITY));
	assign is_empty = (count_q == '0);

	// Search compare on the data read last cycle
	assign srch_hit = sv_s1 && (rdata_s1 == key_q);
	assign srch_end = sv_s1 && ((CW'(si_s1) + CW'(1)) == count_q);

	// List tail detection
	assign lp_nx = CW'(lp_q) + CW'(1);
	assign lst   = (lp_nx == count_q) || (32'(lp_nx) == MAX_RESULTS);

	// Memory port control
	always_comb begin
		re    = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		case (state_q)
			S_SRCH: begin
				if (sp_q < count_q && !srch_hit && !srch_end) begin
					re    = 1'b1;
					raddr = sp_q[AW-1:0];
				end
			end
			S_UP: begin
				if (rem_q != '0) begin
					re    = 1'b1;
					raddr = rp_q;
				end
				if (sv_s1) begin
					we    = 1'b1;
					waddr = widx_s1;
					wdata = rdata_s1;
				end else if (rem_q == '0) begin
					we    = 1'b1;
					waddr = pos_q;
					wdata = val_q;
				end
			end
			S_DN: begin
				if (rem_q != '0) begin
					re    = 1'b1;
					raddr = rp_q;
				end
				if (sv_s1 && !first_s1) begin
					we    = 1'b1;
					waddr = widx_s1;
					wdata = rdata_s1;
				end
			end
			S_LRD: begin
				re    = 1'b1;
				raddr = lp_q;
			end
			default: begin
			end
		endcase
	end

	// Element store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

	// Command dispatch on accept and on search completion
	always_comb begin
		go_emit        = 1'b0;
		go_srch        = 1'b0;
		go_up          = 1'b0;
		go_dn          = 1'b0;
		go_list        = 1'b0;
		new_pos        = '0;
		new_res.status = ST_OK;
		new_res.index  = '0;
		new_res.data   = '0;
		new_res.count  = '0;
		new_res.last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (func)
						FN_SEARCH, FN_DEL_AFTER, FN_DEL_BEFORE: begin
							if (is_empty) begin
								go_emit        = 1'b1;
								new_res.status = ST_EMPTY;
							end else begin
								go_srch = 1'b1;
							end
						end
						FN_INS_AFTER, FN_INS_BEFORE: begin
							if (is_full) begin
								go_emit        = 1'b1;
								new_res.status = ST_FULL;
							end else if (is_empty) begin
								// no element to anchor on
								go_emit        = 1'b1;
								new_res.status = ST_NOTFOUND;
							end else begin
								go_srch = 1'b1;
							end
						end
						FN_INS_FRONT: begin
							if (is_full) begin
								go_emit        = 1'b1;
								new_res.status = ST_FULL;
							end else begin
								go_up = 1'b1;
							end
						end
						FN_INS_END: begin
							if (is_full) begin
								go_emit        = 1'b1;
								new_res.status = ST_FULL;
							end else begin
								go_up   = 1'b1;
								new_pos = AW'(count_q);
							end
						end
						FN_DEL_FRONT: begin
							if (is_empty) begin
								go_emit        = 1'b1;
								new_res.status = ST_EMPTY;
							end else begin
								go_dn = 1'b1;
							end
						end
						FN_DEL_END: begin
							if (is_empty) begin
								go_emit        = 1'b1;
								new_res.status = ST_EMPTY;
							end else begin
								go_dn   = 1'b1;
								new_pos = AW'(count_q - CW'(1));
							end
						end
						FN_LIST: begin
							if (is_empty) begin
								go_emit        = 1'b1;
								new_res.status = ST_EMPTY;
							end else begin
								go_list = 1'b1;
							end
						end
						default: begin
							go_emit = 1'b1;
						end
					endcase
				end
			end
			S_SRCH: begin
				if (srch_hit) begin
					case (func_q)
						FN_SEARCH: begin
							go_emit       = 1'b1;
							new_res.index = IDX_W'(si_s1);
							new_res.data  = key_q;
						end
						FN_INS_AFTER: begin
							go_up   = 1'b1;
							new_pos = si_s1 + AW'(1);
						end
						FN_INS_BEFORE: begin
							go_up   = 1'b1;
							new_pos = si_s1;
						end
						FN_DEL_AFTER: begin
							if (srch_end) begin
								go_emit        = 1'b1;
								new_res.status = ST_NONEIGHBOR;
								new_res.index  = IDX_W'(si_s1);
								new_res.data   = key_q;
							end else begin
								go_dn   = 1'b1;
								new_pos = si_s1 + AW'(1);
							end
						end
						FN_DEL_BEFORE: begin
							if (si_s1 == '0) begin
								go_emit        = 1'b1;
								new_res.status = ST_NONEIGHBOR;
								new_res.data   = key_q;
							end else begin
								go_dn   = 1'b1;
								new_pos = si_s1 - AW'(1);
							end
						end
						default: begin
							go_emit = 1'b1;
						end
					endcase
				end else if (srch_end) begin
					go_emit        = 1'b1;
					new_res.status = ST_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			sv_s1    <= 1'b0;
			first_s1 <= 1'b0;
			si_s1    <= '0;
			widx_s1  <= '0;
			func_q   <= '0;
			key_q    <= '0;
			val_q    <= '0;
			pos_q    <= '0;
			rp_q     <= '0;
			rem_q    <= '0;
			sp_q     <= '0;
			lp_q     <= '0;
			more_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			sv_s1 <= re;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						key_q  <= key;
						val_q  <= value;
						sp_q   <= '0;
						lp_q   <= '0;
						more_q <= 1'b0;
					end
				end
				S_SRCH: begin
					if (re) begin
						sp_q  <= sp_q + CW'(1);
						si_s1 <= sp_q[AW-1:0];
					end
				end
				// Shift up, highest element first, then write the new value
				S_UP: begin
					if (rem_q != '0) begin
						widx_s1 <= rp_q + AW'(1);
						rp_q    <= rp_q - AW'(1);
						rem_q   <= rem_q - CW'(1);
					end else if (!sv_s1) begin
						count_q      <= count_q + CW'(1);
						res_q.status <= ST_OK;
						res_q.index  <= IDX_W'(pos_q);
						res_q.data   <= val_q;
						res_q.last   <= 1'b1;
						state_q      <= S_EMIT;
					end
				end
				// Read the removed element, then shift the rest down
				S_DN: begin
					if (rem_q != '0) begin
						first_s1 <= (rp_q == pos_q);
						widx_s1  <= rp_q - AW'(1);
						rp_q     <= rp_q + AW'(1);
						rem_q    <= rem_q - CW'(1);
					end
					if (sv_s1 && first_s1) begin
						res_q.data <= rdata_s1;
					end
					if (rem_q == '0 && !sv_s1) begin
						count_q      <= count_q - CW'(1);
						res_q.status <= ST_OK;
						res_q.index  <= IDX_W'(pos_q);
						res_q.last   <= 1'b1;
						state_q      <= S_EMIT;
					end
				end
				S_LRD: begin
					state_q <= S_LCAP;
				end
				S_LCAP: begin
					res_q.status <= ST_OK;
					res_q.index  <= IDX_W'(lp_q);
					res_q.data   <= rdata_s1;
					res_q.last   <= lst;
					more_q       <= !lst;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (more_q) begin
							lp_q    <= lp_q + AW'(1);
							state_q <= S_LRD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (go_emit) begin
				res_q   <= new_res;
				state_q <= S_EMIT;
			end
			if (go_srch) begin
				state_q <= S_SRCH;
			end
			if (go_list) begin
				state_q <= S_LRD;
			end
			if (go_up) begin
				pos_q   <= new_pos;
				rp_q    <= AW'(count_q - CW'(1));
				rem_q   <= count_q - CW'(new_pos);
				state_q <= S_UP;
			end
			if (go_dn) begin
				pos_q   <= new_pos;
				rp_q    <= new_pos;
				rem_q   <= count_q - CW'(new_pos);
				state_q <= S_DN;
			end
		end
	end

	// Result register; count reflects the list after the command
	always_comb begin
		ld_res       = res_q;
		ld_res.count = CNT_W'(count_q);
	end

	oal_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      ((state_q == S_EMIT) && out_free),
		.res       (ld_res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.index     (index),
		.data      (data),
		.count     (count),
		.last      (last)
	);

	// Shift pipeline never writes the entry it reads in the same cycle
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (waddr != raddr))
		else $error("store read and write hit the same entry");

	// Count moves by at most one per command
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))
		else $error("element count jumped");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	// A non-final result only shows while a list is still running
	a_list_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |->
		(state_q == S_LRD || state_q == S_LCAP || state_q == S_EMIT))
		else $error("non-final result outside a list");

endmodule

`default_nettype wire

@@ design/oal_obuf.sv @@
`default_nettype none

module oal_obuf import oal_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     load,
	input  wire res_t                     res,
	output logic                          free,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [STAT_W-1:0]             status,
	output logic [IDX_W-1:0]              index,
	output logic signed [DATA_W-1:0]      data,
	output logic [CNT_W-1:0]              count,
	output logic                          last
);

	res_t hold_q;
	logic vld_q;

	// Register is free when empty or being drained this cycle
	assign free = !vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hold_q <= res;
		end
	end

	assign out_valid = vld_q;
	assign status    = hold_q.status;
	assign index     = hold_q.index;
	assign data      = hold_q.data;
	assign count     = hold_q.count;
	assign last      = hold_q.last;

endmodule

`default_nettype wire
